>>> design/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg
// Shared types and constants for the moving average tracker: the item
// formats of both channels, the sequencer states and the EMA update modes.
// ----------------------------------------------------------------------------
package mat_pkg;

    // Fixed field widths of the item formats.
    localparam int PRICE_BITS     = 32;
    localparam int WINDOW_BITS    = 13;
    localparam int COUNT_OUT_BITS = 13;

    // One input transaction.
    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic                  append_to_history;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [PRICE_BITS-1:0]     simple_average;
        logic                      simple_valid;
        logic [PRICE_BITS-1:0]     exponential_average;
        logic                      exponential_valid;
        logic                      rejected;
        logic [COUNT_OUT_BITS-1:0] history_count;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    // What the EMA divider result is used for.
    typedef enum logic [1:0] {
        EMA_NONE,
        EMA_SEED,
        EMA_UP,
        EMA_DOWN
    } ema_mode_t;

endpackage

>>> design/mat_ring.sv
// ----------------------------------------------------------------------------
// mat_ring
// Sample history memory: one write port and one registered synchronous
// read port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module mat_ring #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/mat_divider.sv
// ----------------------------------------------------------------------------
// mat_divider
// Unsigned restoring divider that retires two quotient bits per cycle.
// A start pulse loads the operands; done pulses for one cycle when the
// quotient is complete, and the quotient then holds until the next start.
// ----------------------------------------------------------------------------
module mat_divider #(
    parameter int DIVIDEND_W = 45,
    parameter int DIVISOR_W  = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int ITER  = (DIVIDEND_W + 1) / 2;
    localparam int PAD_W = 2 * ITER;
    localparam int ITR_W = $clog2(ITER + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [ITR_W-1:0]     cnt_reg;
    logic [PAD_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] den_reg;

    logic [DIVISOR_W:0]   r1;
    logic [DIVISOR_W:0]   r2;
    logic                 ge1;
    logic                 ge2;
    logic [DIVISOR_W-1:0] rem1;
    logic [DIVISOR_W-1:0] rem2;

    // Two dependent shift-and-subtract steps.
    always_comb
    begin
        r1   = {rem_reg, quo_reg[PAD_W-1]};
        ge1  = (r1 >= {1'b0, den_reg});
        rem1 = ge1 ? DIVISOR_W'(r1 - {1'b0, den_reg}) : r1[DIVISOR_W-1:0];
        r2   = {rem1, quo_reg[PAD_W-2]};
        ge2  = (r2 >= {1'b0, den_reg});
        rem2 = ge2 ? DIVISOR_W'(r2 - {1'b0, den_reg}) : r2[DIVISOR_W-1:0];
    end

    // Control: iteration counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITR_W'(ITER);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITR_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= PAD_W'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PAD_W-3:0], ge1, ge2};
            rem_reg <= rem2;
        end
    end

    assign quotient = quo_reg[DIVIDEND_W-1:0];
    assign done     = done_reg;

endmodule

>>> design/moving_average_tracker_top.sv
// ----------------------------------------------------------------------------
// moving_average_tracker_top
// Simple and exponential moving averages over a ring of Q16.16 samples.
// ----------------------------------------------------------------------------
// One result transaction follows every input transaction. A zero price, or a
// price without the append flag, goes from acceptance straight to the result
// state, and the next input can be taken once its result is loaded. An
// appended price passes through the read, update, start, divide and result
// states; the divide state waits on the two-bit-per-cycle dividers of
// SUM_W = 32 + clog2(HISTORY_DEPTH + 1) bits that run the window average
// and the EMA step side by side, and the next input is taken in the idle
// state after the load. A result that finds the output register still
// occupied waits until that register drains. The ring memory is read for the
// evicted sample and then written with the new one, and the next input is
// taken only after that write, so accesses never overlap. The output
// register lets a new input be accepted while a result still waits. Writing
// the window clears the window sum, the EMA and all counts; the ring itself
// is never cleared, since only written entries are ever used.
module moving_average_tracker_top #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mat_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mat_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [mat_pkg::WINDOW_BITS-1:0] cfg_data
);

    localparam int PB    = mat_pkg::PRICE_BITS;
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DIV_W = CNT_W + 1;
    localparam int SUM_W = PB + CNT_W;
    localparam int CMP_W = ((CNT_W > mat_pkg::WINDOW_BITS) ? CNT_W : mat_pkg::WINDOW_BITS) + 1;

    // Sequencer and held state.
    mat_pkg::state_t    state_reg;
    mat_pkg::state_t    state_next;
    mat_pkg::in_item_t  item_reg;
    mat_pkg::ema_mode_t mode_reg;
    mat_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    logic [CNT_W-1:0] win_reg;
    logic [PTR_W-1:0] wp_reg;
    logic [CNT_W-1:0] held_reg;
    logic [SUM_W-1:0] wsum_reg;
    logic [CNT_W-1:0] seed_cnt_reg;
    logic [SUM_W-1:0] seed_sum_reg;
    logic [PB-1:0]    ema_reg;
    logic [PB-1:0]    sma_reg;
    logic [PB-1:0]    diff_reg;

    // Sequencer outputs.
    logic accept;
    logic rd_en;
    logic wr_en;
    logic div_start;
    logic load_result;

    // Datapath nets.
    logic             cfg_write;
    logic [CMP_W-1:0] wd_ext;
    logic [CNT_W-1:0] win_eff;
    logic [CNT_W:0]   wp_ext;
    logic [CNT_W:0]   win_ext;
    logic [CNT_W:0]   old_wide;
    logic [PTR_W-1:0] old_idx;
    logic [PB-1:0]    rd_data;
    logic             evict;
    logic [SUM_W-1:0] evict_val;
    logic [CNT_W-1:0] seed_cnt_inc;
    logic [SUM_W-1:0] ema_dividend;
    logic [DIV_W-1:0] ema_divisor;
    logic [SUM_W-1:0] sma_q;
    logic [SUM_W-1:0] ema_q;
    logic             sma_done;
    logic             ema_done;
    logic             simple_ok;
    logic             expo_ok;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Effective window: zero acts as one, oversize acts as the ring depth.
    always_comb
    begin
        wd_ext = CMP_W'(cfg_data);
        if (wd_ext == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (wd_ext > CMP_W'(HISTORY_DEPTH))
        begin
            win_eff = CNT_W'(HISTORY_DEPTH);
        end
        else
        begin
            win_eff = CNT_W'(wd_ext);
        end
    end

    // Ring slot of the sample that leaves the window.
    always_comb
    begin
        wp_ext  = (CNT_W + 1)'(wp_reg);
        win_ext = (CNT_W + 1)'(win_reg);
        if (wp_ext >= win_ext)
        begin
            old_wide = wp_ext - win_ext;
        end
        else
        begin
            old_wide = wp_ext + (CNT_W + 1)'(HISTORY_DEPTH) - win_ext;
        end
        old_idx = old_wide[PTR_W-1:0];
    end

    assign evict        = (held_reg >= win_reg);
    assign evict_val    = evict ? SUM_W'(rd_data) : '0;
    assign seed_cnt_inc = seed_cnt_reg + 1'b1;

    // EMA divider operands: seed mean or scaled step.
    always_comb
    begin
        if (mode_reg == mat_pkg::EMA_SEED)
        begin
            ema_dividend = seed_sum_reg;
            ema_divisor  = DIV_W'(win_reg);
        end
        else
        begin
            ema_dividend = SUM_W'({diff_reg, 1'b0});
            ema_divisor  = DIV_W'(win_reg) + 1'b1;
        end
    end

    mat_ring #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (PB)
    ) u_ring (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (old_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (item_reg.price)
    );

    mat_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DIV_W)
    ) u_sma_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wsum_reg),
        .divisor  (DIV_W'(win_reg)),
        .quotient (sma_q),
        .done     (sma_done)
    );

    mat_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DIV_W)
    ) u_ema_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ema_dividend),
        .divisor  (ema_divisor),
        .quotient (ema_q),
        .done     (ema_done)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mat_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and sequencer outputs.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        accept      = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        div_start   = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            mat_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    accept = 1'b1;
                    if ((in_data.price != '0) && in_data.append_to_history)
                    begin
                        state_next = mat_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = mat_pkg::ST_RESULT;
                    end
                end
            end
            mat_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = mat_pkg::ST_UPDATE;
            end
            mat_pkg::ST_UPDATE:
            begin
                wr_en      = 1'b1;
                state_next = mat_pkg::ST_START;
            end
            mat_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = mat_pkg::ST_DIVIDE;
            end
            mat_pkg::ST_DIVIDE:
            begin
                if (sma_done && ema_done)
                begin
                    state_next = mat_pkg::ST_RESULT;
                end
            end
            mat_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_result = 1'b1;
                    state_next  = mat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mat_pkg::ST_IDLE;
            end
        endcase
    end

    // Averaging state: cleared by a window write, updated by appended samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= CNT_W'(1);
            wp_reg       <= '0;
            held_reg     <= '0;
            wsum_reg     <= '0;
            seed_cnt_reg <= '0;
            seed_sum_reg <= '0;
            ema_reg      <= '0;
            mode_reg     <= mat_pkg::EMA_NONE;
        end
        else if (cfg_write)
        begin
            win_reg      <= win_eff;
            wp_reg       <= '0;
            held_reg     <= '0;
            wsum_reg     <= '0;
            seed_cnt_reg <= '0;
            seed_sum_reg <= '0;
            ema_reg      <= '0;
            mode_reg     <= mat_pkg::EMA_NONE;
        end
        else
        begin
            if (wr_en)
            begin
                wsum_reg <= wsum_reg - evict_val + SUM_W'(item_reg.price);
                if (wp_reg == PTR_W'(HISTORY_DEPTH - 1))
                begin
                    wp_reg <= '0;
                end
                else
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
                if (held_reg < CNT_W'(HISTORY_DEPTH))
                begin
                    held_reg <= held_reg + 1'b1;
                end
                if (seed_cnt_reg < win_reg)
                begin
                    seed_sum_reg <= seed_sum_reg + SUM_W'(item_reg.price);
                    seed_cnt_reg <= seed_cnt_inc;
                    mode_reg     <= (seed_cnt_inc == win_reg) ? mat_pkg::EMA_SEED
                                                              : mat_pkg::EMA_NONE;
                end
                else if (item_reg.price >= ema_reg)
                begin
                    mode_reg <= mat_pkg::EMA_UP;
                end
                else
                begin
                    mode_reg <= mat_pkg::EMA_DOWN;
                end
            end
            // Apply the EMA quotient once both divisions finish.
            if ((state_reg == mat_pkg::ST_DIVIDE) && sma_done && ema_done)
            begin
                case (mode_reg)
                    mat_pkg::EMA_SEED: ema_reg <= ema_q[PB-1:0];
                    mat_pkg::EMA_UP:   ema_reg <= ema_reg + ema_q[PB-1:0];
                    mat_pkg::EMA_DOWN: ema_reg <= ema_reg - ema_q[PB-1:0];
                    default:           ema_reg <= ema_reg;
                endcase
            end
        end
    end

    // Payload registers: the accepted item, the price distance and the
    // last window mean.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (wr_en)
        begin
            diff_reg <= (item_reg.price >= ema_reg) ? item_reg.price - ema_reg
                                                    : ema_reg - item_reg.price;
        end
        if ((state_reg == mat_pkg::ST_DIVIDE) && sma_done && ema_done)
        begin
            sma_reg <= sma_q[PB-1:0];
        end
    end

    // Result transaction register.
    assign simple_ok = (held_reg >= win_reg);
    assign expo_ok   = (seed_cnt_reg >= win_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_reg.simple_average      <= simple_ok ? sma_reg : '0;
            out_reg.simple_valid        <= simple_ok;
            out_reg.exponential_average <= expo_ok ? ema_reg : '0;
            out_reg.exponential_valid   <= expo_ok;
            out_reg.rejected            <= (item_reg.price == '0);
            out_reg.history_count       <= mat_pkg::COUNT_OUT_BITS'(held_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
